>>> rtl/rqir_pkg.sv
// ----------------------------------------------------------------------------
// rqir_pkg: shared types and helpers for the ring queue
// Widths, operation and status codes, sequencer states, pointer wrap helpers.
// ----------------------------------------------------------------------------
package rqir_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [STAT_W-1:0] stat_t;
    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic signed [DATA_W-1:0] data_t;

    localparam func_t FUNC_PUSH   = 2'd0;
    localparam func_t FUNC_POP    = 2'd1;
    localparam func_t FUNC_REMOVE = 2'd2;

    localparam stat_t STAT_OK        = 2'd0;
    localparam stat_t STAT_FULL      = 2'd1;
    localparam stat_t STAT_EMPTY     = 2'd2;
    localparam stat_t STAT_BAD_INDEX = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RM_FIRST,
        ST_RM_SHIFT,
        ST_HEAD_RD,
        ST_FINISH
    } state_t;

    // capacity clamp: zero acts as one, above DEPTH acts as DEPTH
    function automatic cnt_t eff_cap(input cnt_t v);
        cnt_t r;
        r = v;
        if (v == '0)
        begin
            r = CNT_W'(1);
        end
        else if (v > CNT_W'(DEPTH))
        begin
            r = CNT_W'(DEPTH);
        end
        return r;
    endfunction

    function automatic ptr_t wrap_inc(input ptr_t p, input cnt_t cap);
        cnt_t s;
        s = CNT_W'(p) + CNT_W'(1);
        return (s >= cap) ? '0 : s[PTR_W-1:0];
    endfunction

    function automatic ptr_t wrap_dec(input ptr_t p, input cnt_t cap);
        cnt_t c;
        c = cap - CNT_W'(1);
        return (p == '0) ? c[PTR_W-1:0] : p - PTR_W'(1);
    endfunction

endpackage

>>> rtl/ring_queue_with_indexed_remove.sv
// ----------------------------------------------------------------------------
// ring_queue_with_indexed_remove: circular queue with remove at index
// Push, pop and remove-at-position over a 16-entry ring held in a
// one-write, one-read memory; a small sequencer closes the gap after a remove.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  --------  -------------------  ---------------------------------------------
//  request   start / busy         func, push_value, position
//  result    done (1-cycle pulse) status, removed_value, head_value,
//                                 head_valid, entry_count
//  config    cfg_valid/cfg_ready  cfg_data (capacity)
//
//  A request word is taken when start is high and busy low. Push, pop, an
//  invalid request and the unused func code step through EXEC, HEAD_RD and
//  FINISH; a remove steps through EXEC, RM_FIRST, RM_SHIFT once per entry behind
//  the removed one, HEAD_RD and FINISH. The single read port is why the gap is
//  closed one entry a cycle. done pulses for one cycle; there is no backpressure,
//  so the receiver must take the word then. Reset empties the queue and sets
//  capacity to 16; slot contents are undefined until written. A capacity
//  write (only while idle) also empties the queue.
//
module ring_queue_with_indexed_remove (
    input  logic                   clk,
    input  logic                   rst_n,
    // request
    input  logic                   start,
    output logic                   busy,
    input  rqir_pkg::func_t        func,
    input  rqir_pkg::data_t        push_value,
    input  rqir_pkg::ptr_t         position,
    // result
    output logic                   done,
    output rqir_pkg::stat_t        status,
    output rqir_pkg::data_t        removed_value,
    output rqir_pkg::data_t        head_value,
    output logic                   head_valid,
    output rqir_pkg::cnt_t         entry_count,
    // configuration
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  rqir_pkg::cnt_t         cfg_data
);

    import rqir_pkg::*;

    // slot storage: one write port, one registered read port
    data_t  slots_mem [DEPTH];
    data_t  rd_data_reg;
    ptr_t   rd_addr;
    logic   mem_we;
    ptr_t   mem_waddr;
    data_t  mem_wdata;

    // control state
    state_t state_reg, state_next;
    cnt_t   cap_reg, cap_next;
    ptr_t   head_reg, head_next;
    ptr_t   tail_reg, tail_next;
    cnt_t   occ_reg, occ_next;

    // per-request payload
    func_t  func_reg, func_next;
    data_t  value_reg, value_next;
    ptr_t   pos_reg, pos_next;
    ptr_t   wptr_reg, wptr_next;     // slot being overwritten during the shift
    ptr_t   rptr_reg, rptr_next;     // slot whose word moves down next
    cnt_t   k_reg, k_next;           // logical index of the entry moving next
    stat_t  status_reg, status_next;
    data_t  removed_reg, removed_next;

    // physical slot of the remove target: head + position, wrapped once
    cnt_t   pos_sum;
    ptr_t   p_calc;
    logic   cfg_wr;
    logic   rm_ok;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_wr    = cfg_valid && cfg_ready;

    assign pos_sum = CNT_W'(head_reg) + CNT_W'(pos_reg);
    assign p_calc  = (pos_sum >= cap_reg) ? PTR_W'(pos_sum - cap_reg) : pos_sum[PTR_W-1:0];
    assign rm_ok   = (CNT_W'(pos_reg) < occ_reg);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if ((func_reg == FUNC_REMOVE) && rm_ok)
                begin
                    state_next = ST_RM_FIRST;
                end
                else
                begin
                    state_next = ST_HEAD_RD;
                end
            end
            // occ_reg is already decremented here, so "k <= occ" means
            // another entry sits behind the gap
            ST_RM_FIRST:
            begin
                state_next = (k_reg <= occ_reg) ? ST_RM_SHIFT : ST_HEAD_RD;
            end
            ST_RM_SHIFT:
            begin
                state_next = ((k_reg + CNT_W'(1)) <= occ_reg) ? ST_RM_SHIFT : ST_HEAD_RD;
            end
            ST_HEAD_RD:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- datapath and memory control ----------------
    always_comb
    begin
        cap_next     = cap_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        occ_next     = occ_reg;
        func_next    = func_reg;
        value_next   = value_reg;
        pos_next     = pos_reg;
        wptr_next    = wptr_reg;
        rptr_next    = rptr_reg;
        k_next       = k_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        mem_we       = 1'b0;
        mem_waddr    = wptr_reg;
        mem_wdata    = rd_data_reg;
        rd_addr      = head_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_wr)
                begin
                    cap_next  = eff_cap(cfg_data);
                    head_next = '0;
                    tail_next = '0;
                    occ_next  = '0;
                end
                if (start)
                begin
                    func_next  = func;
                    value_next = push_value;
                    pos_next   = position;
                end
            end
            ST_EXEC:
            begin
                status_next  = STAT_OK;
                removed_next = '0;
                case (func_reg)
                    FUNC_PUSH:
                    begin
                        if (occ_reg >= cap_reg)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = tail_reg;
                            mem_wdata = value_reg;
                            tail_next = wrap_inc(tail_reg, cap_reg);
                            occ_next  = occ_reg + CNT_W'(1);
                        end
                    end
                    FUNC_POP:
                    begin
                        if (occ_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            head_next = wrap_inc(head_reg, cap_reg);
                            occ_next  = occ_reg - CNT_W'(1);
                        end
                    end
                    FUNC_REMOVE:
                    begin
                        if (!rm_ok)
                        begin
                            status_next = STAT_BAD_INDEX;
                        end
                        else
                        begin
                            rd_addr   = p_calc;
                            wptr_next = p_calc;
                            rptr_next = wrap_inc(p_calc, cap_reg);
                            k_next    = CNT_W'(pos_reg) + CNT_W'(1);
                            tail_next = wrap_dec(tail_reg, cap_reg);
                            occ_next  = occ_reg - CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        status_next = STAT_OK;
                    end
                endcase
            end
            ST_RM_FIRST:
            begin
                removed_next = rd_data_reg;
                rd_addr      = rptr_reg;
            end
            ST_RM_SHIFT:
            begin
                // rd_data_reg holds slot rptr; move it into slot wptr
                mem_we    = 1'b1;
                mem_waddr = wptr_reg;
                mem_wdata = rd_data_reg;
                wptr_next = rptr_reg;
                rptr_next = wrap_inc(rptr_reg, cap_reg);
                rd_addr   = wrap_inc(rptr_reg, cap_reg);
                k_next    = k_reg + CNT_W'(1);
            end
            ST_HEAD_RD:
            begin
                rd_addr = head_reg;
            end
            default:
            begin
                rd_addr = head_reg;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= CNT_W'(DEPTH);
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        value_reg   <= value_next;
        pos_reg     <= pos_next;
        wptr_reg    <= wptr_next;
        rptr_reg    <= rptr_next;
        k_reg       <= k_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    // slot memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slots_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= slots_mem[rd_addr];
    end

    // ---------------- result word ----------------
    assign done          = (state_reg == ST_FINISH);
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign head_valid    = (occ_reg != '0);
    assign head_value    = head_valid ? rd_data_reg : '0;
    assign entry_count   = occ_reg;

    // ---------------- assertions ----------------
    a_occ_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= cap_reg)
        else $error("occupancy above capacity");

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(head_reg) < cap_reg) && (CNT_W'(tail_reg) < cap_reg))
        else $error("pointer outside capacity");

    a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != STAT_OK) |-> (removed_value == '0))
        else $error("removed value on failed request");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without a request");

    a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RM_SHIFT) |-> (k_reg <= occ_reg))
        else $error("shift beyond last entry");

endmodule

>>> tb/ring_queue_with_indexed_remove_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_queue_with_indexed_remove_tb: self-checking bench for the ring queue
// Drives push, pop and remove-at-index words through the start/busy port. A
// cycle-free model of the queue predicts each done word, and every field is
// compared. The capacity register is swept across its clamped ends. The
// sender idles at three different rates.
// ----------------------------------------------------------------------------

// Scoreboard: keeps its own copy of the ring and the capacity, predicts the
// result word of every accepted request, and checks done words in order.
class queue_checker;

    typedef struct {
        rqir_pkg::stat_t status;
        rqir_pkg::data_t removed;
        rqir_pkg::data_t head;
        logic            head_valid;
        rqir_pkg::cnt_t  count;
    } result_word_t;

    rqir_pkg::data_t ring_slots [rqir_pkg::DEPTH];
    rqir_pkg::ptr_t  head_idx;
    rqir_pkg::ptr_t  tail_idx;
    rqir_pkg::cnt_t  fill;
    rqir_pkg::cnt_t  cap_raw;
    result_word_t    expected_words [$];

    int mismatches;
    int requests_seen;
    int results_seen;
    int status_seen [4];
    int removes_done;
    int unused_ops;
    int cap_writes;

    function new();
        cap_raw = rqir_pkg::cnt_t'(rqir_pkg::DEPTH);
        head_idx = '0;
        tail_idx = '0;
        fill = '0;
        mismatches = 0;
        requests_seen = 0;
        results_seen = 0;
        removes_done = 0;
        unused_ops = 0;
        cap_writes = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // clamped capacity: 0 behaves as 1, anything above DEPTH as DEPTH
    function int cap_used();
        int c;
        c = int'(cap_raw);
        if (c == 0) c = 1;
        if (c > rqir_pkg::DEPTH) c = rqir_pkg::DEPTH;
        return c;
    endfunction

    function int next_slot(int p);
        return (p + 1 >= cap_used()) ? 0 : p + 1;
    endfunction

    function int fill_level();
        return int'(fill);
    endfunction

    function int outstanding();
        return expected_words.size();
    endfunction

    // a capacity write also empties the queue
    function void set_capacity(rqir_pkg::cnt_t v);
        cap_raw = v;
        head_idx = '0;
        tail_idx = '0;
        fill = '0;
        cap_writes++;
    endfunction

    function void note_request(rqir_pkg::func_t op, rqir_pkg::data_t value,
                               rqir_pkg::ptr_t pos);
        result_word_t w;
        int cap;
        int p;
        int nx;
        int k;
        cap = cap_used();
        w.status = rqir_pkg::STAT_OK;
        w.removed = '0;
        requests_seen++;
        case (op)
            rqir_pkg::FUNC_PUSH:
            begin
                if (int'(fill) >= cap)
                begin
                    w.status = rqir_pkg::STAT_FULL;
                end
                else
                begin
                    ring_slots[tail_idx] = value;
                    tail_idx = rqir_pkg::ptr_t'(next_slot(int'(tail_idx)));
                    fill = fill + rqir_pkg::cnt_t'(1);
                end
            end
            rqir_pkg::FUNC_POP:
            begin
                if (fill == '0)
                begin
                    w.status = rqir_pkg::STAT_EMPTY;
                end
                else
                begin
                    head_idx = rqir_pkg::ptr_t'(next_slot(int'(head_idx)));
                    fill = fill - rqir_pkg::cnt_t'(1);
                end
            end
            rqir_pkg::FUNC_REMOVE:
            begin
                if (int'(pos) >= int'(fill))
                begin
                    w.status = rqir_pkg::STAT_BAD_INDEX;
                end
                else
                begin
                    p = (int'(head_idx) + int'(pos)) % cap;
                    w.removed = ring_slots[p];
                    // later entries slide one slot toward the head
                    for (k = int'(pos) + 1; k < int'(fill); k++)
                    begin
                        nx = next_slot(p);
                        ring_slots[p] = ring_slots[nx];
                        p = nx;
                    end
                    tail_idx = (tail_idx == '0) ? rqir_pkg::ptr_t'(cap - 1)
                                                : tail_idx - rqir_pkg::ptr_t'(1);
                    fill = fill - rqir_pkg::cnt_t'(1);
                    removes_done++;
                end
            end
            default:
            begin
                unused_ops++;
            end
        endcase
        w.head = (fill != '0) ? ring_slots[head_idx] : '0;
        w.head_valid = (fill != '0);
        w.count = fill;
        status_seen[w.status]++;
        expected_words.push_back(w);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR word %0d %s: got 0x%08h, expected 0x%08h",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    task check_result(rqir_pkg::stat_t st, rqir_pkg::data_t rem, rqir_pkg::data_t hd,
                      logic hv, rqir_pkg::cnt_t cnt);
        result_word_t w;
        results_seen++;
        if (expected_words.size() == 0)
        begin
            report_mismatch("done with no request outstanding", {30'd0, st}, '0);
        end
        else
        begin
            w = expected_words.pop_front();
            if (st !== w.status) report_mismatch("status", {30'd0, st}, {30'd0, w.status});
            if (rem !== w.removed) report_mismatch("removed_value", rem, w.removed);
            if (hd !== w.head) report_mismatch("head_value", hd, w.head);
            if (hv !== w.head_valid)
                report_mismatch("head_valid", {31'd0, hv}, {31'd0, w.head_valid});
            if (cnt !== w.count) report_mismatch("entry_count", {27'd0, cnt}, {27'd0, w.count});
        end
    endtask

    task flag_leftovers();
        if (expected_words.size() != 0)
        begin
            report_mismatch("results never delivered", expected_words.size(), 0);
        end
    endtask

endclass

module ring_queue_with_indexed_remove_tb;

    // func code 3 is unused by the block: a no-op that still reports
    localparam rqir_pkg::func_t FUNC_UNUSED = 2'd3;
    // quiet cycles (nothing accepted, no done) before the run is called hung
    localparam int QUIET_LIMIT = 2000;
    // settle time after the last done word
    localparam int TAIL_CYCLES = 40;
    localparam int SEGMENTS = 6;
    localparam int ITEMS_PER_SEGMENT = 165;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    rqir_pkg::func_t      func = rqir_pkg::FUNC_PUSH;
    rqir_pkg::data_t      push_value = '0;
    rqir_pkg::ptr_t       position = '0;
    logic                 done;
    rqir_pkg::stat_t      status;
    rqir_pkg::data_t      removed_value;
    rqir_pkg::data_t      head_value;
    logic                 head_valid;
    rqir_pkg::cnt_t       entry_count;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    rqir_pkg::cnt_t       cfg_data = '0;

    queue_checker sb;
    int  sender_idle_pct = 0;
    int  quiet_cycles = 0;
    // stimulus shaping: fill the ring up, then work it back down
    bit  filling = 1'b1;

    // capacity per random segment: nominal, both clamp ends, odd sizes
    rqir_pkg::cnt_t seg_caps [SEGMENTS] = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd11};

    ring_queue_with_indexed_remove u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .push_value    (push_value),
        .position      (position),
        .done          (done),
        .status        (status),
        .removed_value (removed_value),
        .head_value    (head_value),
        .head_valid    (head_valid),
        .entry_count   (entry_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, before the block's
    // own nonblocking updates land. A done word is checked before a request
    // taken at the same edge is noted, since it belongs to an older one.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                sb.check_result(status, removed_value, head_value, head_valid, entry_count);
            end
            if (start && !busy)
            begin
                sb.note_request(func, push_value, position);
            end
            if (cfg_valid && cfg_ready)
            begin
                sb.set_capacity(cfg_data);
            end
            if (done || (start && !busy) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offer one request word and hold it until the block takes it. start is
    // left high on return so back-to-back words need no extra edge.
    task automatic issue_request(input rqir_pkg::func_t f, input logic [31:0] v,
                                 input rqir_pkg::ptr_t p);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        func       <= f;
        push_value <= v;
        position   <= p;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    // Stop sending and wait until every predicted word has come back.
    task automatic drain_results();
        start <= 1'b0;
        repeat (2) @(posedge clk);
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Capacity writes only happen with the block idle; the write empties it.
    task automatic write_capacity(input rqir_pkg::cnt_t v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed traffic: fill to capacity, then pop and remove at
    // valid positions back to empty. About one word in ten is noise (any
    // operation, any position), plus a few unused-code words.
    task automatic random_item();
        int occ;
        int cap;
        int pick;
        rqir_pkg::func_t f;
        logic [31:0] v;
        rqir_pkg::ptr_t p;
        occ = sb.fill_level();
        cap = sb.cap_used();
        v = $urandom;
        p = rqir_pkg::ptr_t'($urandom_range(15));
        if (occ == 0) filling = 1'b1;
        else if (occ >= cap) filling = 1'b0;
        pick = $urandom_range(99);
        if (pick < 3)
        begin
            f = FUNC_UNUSED;
        end
        else if (pick < 13)
        begin
            f = rqir_pkg::func_t'($urandom_range(2));
        end
        else
        begin
            if ($urandom_range(99) < 85)
                f = filling ? rqir_pkg::FUNC_PUSH
                            : ($urandom_range(1) ? rqir_pkg::FUNC_POP : rqir_pkg::FUNC_REMOVE);
            else
                f = filling ? ($urandom_range(1) ? rqir_pkg::FUNC_POP : rqir_pkg::FUNC_REMOVE)
                            : rqir_pkg::FUNC_PUSH;
            if (f == rqir_pkg::FUNC_REMOVE && occ > 0)
                p = rqir_pkg::ptr_t'($urandom_range(occ - 1));
        end
        if ($urandom_range(15) == 0)
        begin
            case ($urandom_range(3))
                0: v = 32'h8000_0000;
                1: v = 32'h7fff_ffff;
                2: v = 32'h0000_0000;
                default: v = 32'hffff_ffff;
            endcase
        end
        issue_request(f, v, p);
    endtask

    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: empty-queue errors, extreme values, removes at the
        // --- head, middle and tail, out-of-range index, unused code
        issue_request(rqir_pkg::FUNC_POP,    32'h0, 4'd0);
        issue_request(rqir_pkg::FUNC_REMOVE, 32'h0, 4'd0);
        issue_request(FUNC_UNUSED,           32'h0, 4'd0);
        issue_request(rqir_pkg::FUNC_PUSH,   32'h8000_0000, 4'd0);
        issue_request(rqir_pkg::FUNC_PUSH,   32'h7fff_ffff, 4'd0);
        issue_request(rqir_pkg::FUNC_PUSH,   32'h0000_0000, 4'd0);
        issue_request(rqir_pkg::FUNC_PUSH,   32'hffff_ffff, 4'd0);
        issue_request(rqir_pkg::FUNC_PUSH,   32'h5a5a_a5a5, 4'd0);
        issue_request(rqir_pkg::FUNC_REMOVE, 32'h0, 4'd15);
        issue_request(rqir_pkg::FUNC_REMOVE, 32'h0, 4'd1);
        issue_request(rqir_pkg::FUNC_REMOVE, 32'h0, 4'd3);
        issue_request(rqir_pkg::FUNC_REMOVE, 32'h0, 4'd0);
        issue_request(FUNC_UNUSED,           32'h1234_5678, 4'd7);
        issue_request(rqir_pkg::FUNC_POP,    32'h0, 4'd0);
        issue_request(rqir_pkg::FUNC_POP,    32'h0, 4'd0);
        issue_request(rqir_pkg::FUNC_POP,    32'h0, 4'd0);

        // capacity 0 clamps to a single slot: second push is dropped
        write_capacity(5'd0);
        issue_request(rqir_pkg::FUNC_PUSH,   32'h1234_5678, 4'd0);
        issue_request(rqir_pkg::FUNC_PUSH,   32'h0bad_f00d, 4'd0);
        issue_request(rqir_pkg::FUNC_REMOVE, 32'h0, 4'd0);
        issue_request(rqir_pkg::FUNC_PUSH,   32'hcafe_0001, 4'd0);

        // two slots: pointers wrap, remove across the wrap point
        write_capacity(5'd2);
        issue_request(rqir_pkg::FUNC_PUSH,   32'h0000_00a1, 4'd0);
        issue_request(rqir_pkg::FUNC_POP,    32'h0, 4'd0);
        issue_request(rqir_pkg::FUNC_PUSH,   32'h0000_00b2, 4'd0);
        issue_request(rqir_pkg::FUNC_PUSH,   32'h0000_00c3, 4'd0);
        issue_request(rqir_pkg::FUNC_PUSH,   32'h0000_00d4, 4'd0);
        issue_request(rqir_pkg::FUNC_REMOVE, 32'h0, 4'd1);

        // --- random segments: each sets a capacity, then the sender idles
        // --- at 21%, then 69%, then not at all; an occasional full drain
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            sender_idle_pct = (seg < 2) ? 21 : ((seg < 4) ? 69 : 0);
            write_capacity(seg_caps[seg]);
            filling = 1'b1;
            for (int n = 0; n < ITEMS_PER_SEGMENT; n++)
            begin
                if ($urandom_range(63) == 0)
                begin
                    drain_results();
                end
                random_item();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.flag_leftovers();

        $display("Run covered %0d requests and %0d result words over %0d capacity writes",
                 sb.requests_seen, sb.results_seen, sb.cap_writes);
        $display("  full pushes %0d, empty pops %0d, bad indexes %0d, removes %0d, no-ops %0d",
                 sb.status_seen[rqir_pkg::STAT_FULL], sb.status_seen[rqir_pkg::STAT_EMPTY],
                 sb.status_seen[rqir_pkg::STAT_BAD_INDEX], sb.removes_done, sb.unused_ops);
        if (sb.mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/rqir_pkg.sv
rtl/ring_queue_with_indexed_remove.sv
tb/ring_queue_with_indexed_remove_tb.sv
